/* hw/rtl/ble_channel_select_one_core_defines.svh */
// Assertion macros shared by the channel selection RTL.
// Needs nothing else; included by the files that assert.
`ifndef BLE_CHANNEL_SELECT_ONE_CORE_DEFINES_SVH
`define BLE_CHANNEL_SELECT_ONE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define BCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ble_cs1_pkg.sv */
// Constants and register codes for the channel selection core.
// No dependencies.
package ble_cs1_pkg;

    localparam int NUM_CH    = 37;
    localparam int CH_W      = 6;
    localparam int MAP_W     = 37;
    localparam int HOP_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_INCREMENT = 2'd1;

    localparam logic [MAP_W-1:0] MAP_RESET   = {MAP_W{1'b1}};
    localparam logic [HOP_W-1:0] HOP_RESET   = 5'd5;
    localparam logic [CH_W-1:0]  COUNT_RESET = 6'd37;
    localparam logic [CH_W-1:0]  LAST_CH     = 6'd36;
    localparam logic [CH_W:0]    NUM_CH_W    = 7'd37;

endpackage

/* hw/rtl/ble_channel_select_one_core.sv */
// Data channel selection (algorithm 1) for connection events.
// Uses ble_cs1_pkg and ble_channel_select_one_core_defines.svh.
// Usage
//   Input channel (i_in_valid / o_in_ready): one item per connection
//   event; i_new_connection restarts the hop sequence at 0.
//   Output channel (o_out_valid / i_out_ready): one item per input with
//   data channel, unmapped channel, remap flag and empty-map flag.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is
//   the 37-bit channel map, index 1 the 5-bit hop; other indexes ignored.
// Timing
//   A direct hit or an empty map goes from acceptance through S_HOLD into
//   the output register. A remap runs on one shared 7-bit add/subtract unit:
//   repeated subtraction of the count in S_MOD, a scan of the channels
//   in S_SCAN up to the rank, then the load from S_HOLD.
//   Input is ready again the cycle after the load, one item at a time.
//   A channel-map write starts a recount in S_COUNT; items wait meanwhile.
// Reset and stall
//   Reset gives an all-used map, hop 5, last unmapped channel 0, count 37.
//   A stalled output holds its item; the core finishes the next item and
//   waits with it until the output register frees.
`include "ble_channel_select_one_core_defines.svh"

module ble_channel_select_one_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_new_connection,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ble_cs1_pkg::CH_W-1:0]      o_data_channel,
    output logic [ble_cs1_pkg::CH_W-1:0]      o_unmapped_channel,
    output logic                              o_was_remapped,
    output logic                              o_map_empty,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ble_cs1_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ble_cs1_pkg::MAP_W-1:0]     i_cfg_data
);
    import ble_cs1_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_MOD,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state             r_state, n_state;
    logic [MAP_W-1:0]   r_map, n_map;
    logic [HOP_W-1:0]   r_hop, n_hop;
    logic [CH_W-1:0]    r_last, n_last;
    logic [CH_W-1:0]    r_count, n_count;
    logic [CH_W-1:0]    r_idx, n_idx;
    logic [CH_W-1:0]    r_seen, n_seen;
    logic [CH_W-1:0]    r_rem, n_rem;
    logic [CH_W-1:0]    r_data, n_data;
    logic [CH_W-1:0]    r_unm, n_unm;
    logic               r_remap, n_remap;
    logic               r_empty, n_empty;
    logic               r_out_valid, n_out_valid;
    logic [CH_W-1:0]    r_o_data, n_o_data;
    logic [CH_W-1:0]    r_o_unm, n_o_unm;
    logic               r_o_remap, n_o_remap;
    logic               r_o_empty, n_o_empty;

    // shared add/subtract unit
    logic [CH_W:0]      alu_a, alu_b, alu_y;
    logic               alu_sub;

    logic               in_acc, cfg_acc, out_free;
    logic [CH_W-1:0]    base;
    logic [CH_W:0]      hop_sum;
    logic [CH_W-1:0]    unm_now;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // hop addition, one conditional subtract brings it below 37
    assign base    = i_new_connection ? '0 : r_last;
    assign hop_sum = {1'b0, base} + {{(CH_W+1-HOP_W){1'b0}}, r_hop};
    always_comb begin
        if (hop_sum >= NUM_CH_W) begin
            unm_now = CH_W'(hop_sum - NUM_CH_W);
        end else begin
            unm_now = hop_sum[CH_W-1:0];
        end
    end

    // operand selection for the shared unit
    always_comb begin
        alu_a   = {1'b0, r_seen};
        alu_b   = 7'd1;
        alu_sub = 1'b0;
        case (r_state)
            S_COUNT: begin
                alu_a = {1'b0, r_count};
                alu_b = {{CH_W{1'b0}}, r_map[r_idx]};
            end
            S_MOD: begin
                alu_a   = {1'b0, r_rem};
                alu_b   = {1'b0, r_count};
                alu_sub = 1'b1;
            end
            default: begin
                alu_a = {1'b0, r_seen};
                alu_b = 7'd1;
            end
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_map       = r_map;
        n_hop       = r_hop;
        n_last      = r_last;
        n_count     = r_count;
        n_idx       = r_idx;
        n_seen      = r_seen;
        n_rem       = r_rem;
        n_data      = r_data;
        n_unm       = r_unm;
        n_remap     = r_remap;
        n_empty     = r_empty;
        n_out_valid = r_out_valid;
        n_o_data    = r_o_data;
        n_o_unm     = r_o_unm;
        n_o_remap   = r_o_remap;
        n_o_empty   = r_o_empty;

        // drop the output item once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last  = unm_now;
                    n_unm   = unm_now;
                    n_rem   = unm_now;
                    n_data  = '0;
                    n_remap = 1'b0;
                    n_empty = 1'b0;
                    if (r_count == '0) begin
                        n_empty = 1'b1;
                        n_state = S_HOLD;
                    end else if (r_map[unm_now]) begin
                        n_data  = unm_now;
                        n_state = S_HOLD;
                    end else begin
                        n_remap = 1'b1;
                        n_state = S_MOD;
                    end
                end
            end
            S_COUNT: begin
                // accumulate one map bit a cycle
                n_count = alu_y[CH_W-1:0];
                n_idx   = r_idx + 6'd1;
                if (r_idx == LAST_CH) begin
                    n_state = S_IDLE;
                end
            end
            S_MOD: begin
                // subtract the count until the remainder drops below it
                if (!alu_y[CH_W]) begin
                    n_rem = alu_y[CH_W-1:0];
                end else begin
                    n_idx   = '0;
                    n_seen  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // walk channels upward, stop at the used one of that rank
                n_idx = r_idx + 6'd1;
                if (r_map[r_idx]) begin
                    if (r_seen == r_rem) begin
                        n_data  = r_idx;
                        n_state = S_HOLD;
                    end else begin
                        n_seen = alu_y[CH_W-1:0];
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_data    = r_data;
                    n_o_unm     = r_unm;
                    n_o_remap   = r_remap;
                    n_o_empty   = r_empty;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration writes
        if (cfg_acc) begin
            case (i_cfg_index)
                REG_CHANNEL_MAP: begin
                    n_map   = i_cfg_data;
                    n_count = '0;
                    n_idx   = '0;
                    n_state = S_COUNT;
                end
                REG_HOP_INCREMENT: begin
                    n_hop = i_cfg_data[HOP_W-1:0];
                end
                default: begin
                    n_hop = r_hop;
                end
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map       <= MAP_RESET;
            r_hop       <= HOP_RESET;
            r_last      <= '0;
            r_count     <= COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_hop       <= n_hop;
            r_last      <= n_last;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx     <= n_idx;
        r_seen    <= n_seen;
        r_rem     <= n_rem;
        r_data    <= n_data;
        r_unm     <= n_unm;
        r_remap   <= n_remap;
        r_empty   <= n_empty;
        r_o_data  <= n_o_data;
        r_o_unm   <= n_o_unm;
        r_o_remap <= n_o_remap;
        r_o_empty <= n_o_empty;
    end

    assign o_out_valid        = r_out_valid;
    assign o_data_channel     = r_o_data;
    assign o_unmapped_channel = r_o_unm;
    assign o_was_remapped     = r_o_remap;
    assign o_map_empty        = r_o_empty;

    `BCS_ASSERT_NOW(a_mod_nonzero, i_clk, i_rst_n, r_state == S_MOD, r_count != '0,
        "modulo entered with zero used channels")
    `BCS_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN, r_idx <= LAST_CH,
        "rank scan ran past the last channel")
    `BCS_ASSERT_NOW(a_remap_not_empty, i_clk, i_rst_n, o_out_valid && o_was_remapped,
        !o_map_empty, "remapped item flagged as empty map")
    `BCS_ASSERT_NOW(a_direct_hit, i_clk, i_rst_n,
        o_out_valid && !o_was_remapped && !o_map_empty,
        o_data_channel == o_unmapped_channel, "direct hit differs from unmapped channel")
    `BCS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_in_ready,
        "input ready right after an accepted item")

endmodule

/* test/tb.sv */
// Self-checking testbench for ble_channel_select_one_core (hop sequence and channel remap).
// Depends on ble_cs1_pkg and the core RTL; predicts every result in-line from its own state.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ble_cs1_pkg::*;

    // Register indexes the core does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int STALL_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 9;
    localparam int PHASE_ITEMS     = 110;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [CH_W-1:0] data_ch;
        logic [CH_W-1:0] unmapped_ch;
        logic            remapped;
        logic            empty;
    } t_hop_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_new_connection = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [CH_W-1:0]      o_data_channel;
    logic [CH_W-1:0]      o_unmapped_channel;
    logic                 o_was_remapped;
    logic                 o_map_empty;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [MAP_W-1:0]     i_cfg_data = '0;

    // Predicted copy of the core's configuration and hop state
    logic [MAP_W-1:0] chan_map_q;
    logic [HOP_W-1:0] hop_q;
    logic [CH_W-1:0]  last_unmapped_q;
    int               used_count_q;

    t_hop_result pending_hops[$];

    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_off_start = 1'b0;
    int          hold_off_left = 0;

    int failures = 0;
    int items_sent = 0;
    int results_checked = 0;
    int remapped_seen = 0;
    int empty_seen = 0;
    int reg_writes = 0;
    int input_stall_cycles = 0;
    int quiet_cycles = 0;

    ble_channel_select_one_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_new_connection   (i_new_connection),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_data_channel     (o_data_channel),
        .o_unmapped_channel (o_unmapped_channel),
        .o_was_remapped     (o_was_remapped),
        .o_map_empty        (o_map_empty),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the hop sequence by one connection event and pick the data channel
    function automatic t_hop_result next_hop(input logic new_conn);
        t_hop_result r;
        int          base;
        int          rank;
        int          seen;
        r = '0;
        base = new_conn ? 0 : int'(last_unmapped_q);
        r.unmapped_ch = CH_W'((base + int'(hop_q)) % NUM_CH);
        last_unmapped_q = r.unmapped_ch;
        if (used_count_q == 0) begin
            r.empty = 1'b1;
        end else if (chan_map_q[r.unmapped_ch]) begin
            r.data_ch = r.unmapped_ch;
        end else begin
            // rank among used channels, counting upward from channel 0
            rank = int'(r.unmapped_ch) % used_count_q;
            seen = 0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (chan_map_q[ch]) begin
                    if (seen == rank)
                        r.data_ch = CH_W'(ch);
                    seen++;
                end
            end
            r.remapped = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [MAP_W-1:0] random_map();
        logic [MAP_W-1:0] a;
        logic [MAP_W-1:0] b;
        logic [MAP_W-1:0] c;
        a = MAP_W'({$urandom, $urandom});
        b = MAP_W'({$urandom, $urandom});
        c = MAP_W'({$urandom, $urandom});
        case ($urandom_range(0, 7))
            0: return MAP_RESET;
            1: return '0;
            2: return MAP_W'(1) << $urandom_range(0, NUM_CH - 1);
            3: return a & b & c;
            4: return a | b | c;
            5: return (MAP_W'(1) << $urandom_range(0, NUM_CH - 1)) |
                      (MAP_W'(1) << $urandom_range(0, NUM_CH - 1));
            default: return a;
        endcase
    endfunction

    function automatic logic [MAP_W-1:0] random_hop();
        if ($urandom_range(0, 4) == 0)
            return MAP_W'($urandom_range(0, 31));
        return MAP_W'($urandom_range(5, 16));
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        send_gap_pct = (mode == IDLE_SENDER) ? 63 : (mode == IDLE_BOTH) ? 18 : 0;
        recv_stall_pct <= (mode == IDLE_RECEIVER) ? 63 : (mode == IDLE_BOTH) ? 18 : 0;
    endtask

    // Offer one connection event, hold it until accepted, then queue its prediction
    task automatic send_item(input logic new_conn);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_new_connection <= new_conn;
        do @(posedge i_clk); while (!o_in_ready);
        pending_hops.push_back(next_hop(new_conn));
        items_sent++;
    endtask

    // Write one register once the core has drained, and mirror it in the predictor
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [MAP_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_hops.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            REG_CHANNEL_MAP: begin
                chan_map_q = value;
                used_count_q = $countones(value);
            end
            REG_HOP_INCREMENT: hop_q = value[HOP_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        repeat (3) send_item(1'b0);
        send_item(1'b1);
    endtask

    task automatic test_hop_extremes();
        // a hop of zero repeats the channel
        write_register(REG_HOP_INCREMENT, '0);
        repeat (2) send_item(1'b0);
        // bits above the hop width are dropped, leaving 31
        write_register(REG_HOP_INCREMENT, '1);
        repeat (3) send_item(1'b0);
        write_register(REG_HOP_INCREMENT, MAP_W'(16));
        send_item(1'b1);
        send_item(1'b0);
    endtask

    task automatic test_map_corners();
        logic [MAP_W-1:0] odd_channels;
        odd_channels = 37'h0AAAAAAAAA;
        // empty map raises the flag and gives channel 0
        write_register(REG_CHANNEL_MAP, '0);
        send_item(1'b0);
        send_item(1'b1);
        write_register(REG_CHANNEL_MAP, MAP_W'(1) << LAST_CH);
        repeat (2) send_item(1'b0);
        write_register(REG_CHANNEL_MAP, MAP_W'(1));
        send_item(1'b0);
        write_register(REG_CHANNEL_MAP, odd_channels);
        repeat (2) send_item(1'b0);
        write_register(REG_CHANNEL_MAP, ~odd_channels);
        repeat (2) send_item(1'b0);
        write_register(REG_CHANNEL_MAP, MAP_RESET);
    endtask

    task automatic test_unknown_index();
        // writes to undecoded indexes must leave map and hop alone
        write_register(REG_SPARE_2, '0);
        write_register(REG_SPARE_3, '1);
        repeat (2) send_item(1'b0);
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                write_register(REG_CHANNEL_MAP, MAP_RESET);
                write_register(REG_HOP_INCREMENT, MAP_W'(16));
            end else begin
                write_register(REG_CHANNEL_MAP, random_map());
                write_register(REG_HOP_INCREMENT, random_hop());
            end
            set_idling(t_idle_mode'(phase % 4));
            repeat (PHASE_ITEMS) send_item($urandom_range(99) < 8);
        end
    endtask

    task automatic test_backpressure();
        // sparse map keeps most items on the slow remap path
        write_register(REG_CHANNEL_MAP,
                       MAP_W'({$urandom, $urandom}) & MAP_W'({$urandom, $urandom}));
        set_idling(IDLE_NONE);
        hold_off_start <= 1'b1;
        @(posedge i_clk);
        hold_off_start <= 1'b0;
        repeat (40) send_item($urandom_range(99) < 8);
    endtask

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off_start && hold_off_left == 0)
            hold_off_left = HOLD_OFF_CYCLES;
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_hop_result got;
        t_hop_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_ready)
                input_stall_cycles++;
            if (o_out_valid && i_out_ready) begin
                got = {o_data_channel, o_unmapped_channel, o_was_remapped, o_map_empty};
                if (pending_hops.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%t: result with no item pending: data %0d unmapped %0d",
                                 $realtime, got.data_ch, got.unmapped_ch);
                end else begin
                    want = pending_hops.pop_front();
                    results_checked++;
                    if (got.remapped) remapped_seen++;
                    if (got.empty) empty_seen++;
                    if (got !== want) begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display({"%t: mismatch: data %0d/%0d unmapped %0d/%0d ",
                                      "remapped %0b/%0b empty %0b/%0b (expected/actual)"},
                                     $realtime, want.data_ch, got.data_ch,
                                     want.unmapped_ch, got.unmapped_ch,
                                     want.remapped, got.remapped, want.empty, got.empty);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves an item for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else if (++quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: %0d cycles without any transfer, %0d results pending",
                     STALL_LIMIT, pending_hops.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        chan_map_q = MAP_RESET;
        hop_q = HOP_RESET;
        last_unmapped_q = '0;
        used_count_q = $countones(MAP_RESET);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_hop_extremes();
        test_map_corners();
        test_unknown_index();
        test_random_phases();
        test_backpressure();

        // drain, then allow for a late stray result
        i_in_valid <= 1'b0;
        while (pending_hops.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        failures += pending_hops.size();

        $display("Sent %0d connection events, checked %0d results (%0d remapped, %0d empty map)",
                 items_sent, results_checked, remapped_seen, empty_seen);
        $display("Made %0d register writes; input was held off for %0d cycles",
                 reg_writes, input_stall_cycles);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ble_cs1_pkg.sv
hw/rtl/ble_channel_select_one_core.sv
test/tb.sv
